### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the semaphore core checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CSFW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CSFW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Types and constants shared by the counting semaphore core modules.
// ----------------------------------------------------------------------------
package csfw_pkg;

   // Width of the semaphore count; the count saturates at its top value.
   localparam int unsigned COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Default sizing of the waiter queue and the thread ids.
   localparam int unsigned DEF_MAX_WAITERS = 16;
   localparam int unsigned DEF_ID_BITS     = 8;

   // Register port.
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_INITIAL_COUNT = 2'd0;

   // Request kinds.
   localparam logic REQ_WAIT   = 1'b0;
   localparam logic REQ_SIGNAL = 1'b1;

   typedef enum logic [2:0] {
      OUT_GRANTED   = 3'd0,
      OUT_BLOCKED   = 3'd1,
      OUT_WOKEN     = 3'd2,
      OUT_NO_WAITER = 3'd3,
      OUT_FULL      = 3'd4
   } outcome_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;   // take the offered request and update the semaphore state
      logic load;   // move the staged result into the output register
   } dp_cmd_type;

endpackage

### rtl/core/counting_semaphore_fifo_waiters_core.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_core
// A counting semaphore with a FIFO of blocked thread ids. Each request beat on
// the req_ channel is a wait (req_type 0) or a signal (req_type 1); each one
// gives exactly one result beat on the rsp_ channel, in order. A wait is
// granted while the count is above zero, otherwise its thread id is queued,
// or refused when the queue is full; a signal adds one to the count
// (saturating) and wakes the oldest waiter, if any. One request per cycle is
// sustained while the receiver does not stall: the decision is taken as the
// request is accepted, with a registered read of the queue's head entry, and
// the staged result then enters the output register. When the receiver
// stalls, the result beat holds and at most one further request is taken,
// which waits in the staging registers; req_stall then rises until the output
// register drains. Reset empties the queue, clears initial_count and the
// count to zero and drops rsp_valid; the queue memory itself is not cleared.
// Writing initial_count loads the count at once and leaves queued waiters in
// place; the user must write it only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_core #(
   parameter int unsigned MAX_WAITERS = csfw_pkg::DEF_MAX_WAITERS,
   parameter int unsigned ID_BITS     = csfw_pkg::DEF_ID_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [ID_BITS-1:0]               req_thread_id,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_outcome,
   output logic [ID_BITS-1:0]               rsp_woken_id,
   output logic [csfw_pkg::COUNT_W-1:0]     rsp_count_now,
   // Register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [csfw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [csfw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [csfw_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   csfw_pkg::dp_cmd_type         cmd;
   logic                         cfg_we;
   logic [csfw_pkg::COUNT_W-1:0] cfg_rdata;
   logic                         sel_initial_count;

   // The register port never inserts wait states. A write to any address
   // other than initial_count is dropped, and reads there return zero.
   assign csr_pready        = 1'b1;
   assign sel_initial_count = (csr_paddr == csfw_pkg::ADDR_INITIAL_COUNT);
   assign cfg_we            = csr_psel && csr_penable && csr_pwrite && sel_initial_count;
   assign csr_prdata        = sel_initial_count ? csfw_pkg::CSR_DATA_W'(cfg_rdata) : '0;

   // The controller owns the handshakes; the datapath holds all payload state.
   csfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   csfw_datapath #(
      .MAX_WAITERS (MAX_WAITERS),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg_we        (cfg_we),
      .cfg_wdata     (csr_pwdata[csfw_pkg::COUNT_W-1:0]),
      .cfg_rdata     (cfg_rdata),
      .req_type      (req_type),
      .req_thread_id (req_thread_id),
      .rsp_outcome   (rsp_outcome),
      .rsp_woken_id  (rsp_woken_id),
      .rsp_count_now (rsp_count_now)
   );

endmodule

### rtl/core/csfw_ctrl.sv
// ----------------------------------------------------------------------------
// csfw_ctrl
// Handshake controller: accepts requests and paces the result register.
// ----------------------------------------------------------------------------
module csfw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output csfw_pkg::dp_cmd_type  cmd
);

   csfw_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // The output register can take a new beat when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csfw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.exec  = 1'b0;
      cmd.load  = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         csfw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = csfw_pkg::ST_EXEC;
            end
         end
         csfw_pkg::ST_EXEC: begin
            if (out_free) begin
               cmd.load  = 1'b1;
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.exec = 1'b1;
               end else begin
                  state_in = csfw_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = csfw_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

endmodule

### rtl/core/csfw_datapath.sv
// ----------------------------------------------------------------------------
// csfw_datapath
// Semaphore count, waiter queue memory, staged result and output register.
// ----------------------------------------------------------------------------
module csfw_datapath #(
   parameter int unsigned MAX_WAITERS = csfw_pkg::DEF_MAX_WAITERS,
   parameter int unsigned ID_BITS     = csfw_pkg::DEF_ID_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  csfw_pkg::dp_cmd_type          cmd,
   input  logic                          cfg_we,
   input  logic [csfw_pkg::COUNT_W-1:0]  cfg_wdata,
   output logic [csfw_pkg::COUNT_W-1:0]  cfg_rdata,
   input  logic                          req_type,
   input  logic [ID_BITS-1:0]            req_thread_id,
   output logic [2:0]                    rsp_outcome,
   output logic [ID_BITS-1:0]            rsp_woken_id,
   output logic [csfw_pkg::COUNT_W-1:0]  rsp_count_now
);

   localparam int unsigned PTR_W  = $clog2(MAX_WAITERS);
   localparam int unsigned FILL_W = $clog2(MAX_WAITERS + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_WAITERS - 1);
   localparam logic [FILL_W-1:0] FILL_TOP = FILL_W'(MAX_WAITERS);

   logic [csfw_pkg::COUNT_W-1:0] initial_count_ff;
   logic [csfw_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [PTR_W-1:0]             tail_ff, tail_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic                         push;
   csfw_pkg::outcome_type        outcome_in;

   logic [ID_BITS-1:0]           queue_mem [MAX_WAITERS];
   logic [ID_BITS-1:0]           head_data_ff;

   csfw_pkg::outcome_type        stage_outcome_ff;
   logic [csfw_pkg::COUNT_W-1:0] stage_count_ff;

   csfw_pkg::outcome_type        rsp_outcome_ff;
   logic [ID_BITS-1:0]           rsp_woken_id_ff;
   logic [csfw_pkg::COUNT_W-1:0] rsp_count_now_ff;

   // Decision for one request, from the state held before it.
   always_comb begin
      count_in   = count_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      push       = 1'b0;
      outcome_in = csfw_pkg::OUT_GRANTED;
      if (req_type == csfw_pkg::REQ_WAIT) begin
         if (count_ff != '0) begin
            count_in   = count_ff - 1'b1;
            outcome_in = csfw_pkg::OUT_GRANTED;
         end else if (fill_ff != FILL_TOP) begin
            push       = 1'b1;
            tail_in    = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
            fill_in    = fill_ff + 1'b1;
            outcome_in = csfw_pkg::OUT_BLOCKED;
         end else begin
            outcome_in = csfw_pkg::OUT_FULL;
         end
      end else begin
         if (count_ff != csfw_pkg::COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         if (fill_ff != '0) begin
            head_in    = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
            fill_in    = fill_ff - 1'b1;
            outcome_in = csfw_pkg::OUT_WOKEN;
         end else begin
            outcome_in = csfw_pkg::OUT_NO_WAITER;
         end
      end
   end

   // Control state of the semaphore and its register.
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_count_ff <= '0;
         count_ff         <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         fill_ff          <= '0;
      end else if (cfg_we) begin
         initial_count_ff <= cfg_wdata;
         count_ff         <= cfg_wdata;
      end else if (cmd.exec) begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
   end

   // Waiter queue: one write port at the tail, registered read at the head.
   always_ff @(posedge clock) begin
      if (cmd.exec && push) begin
         queue_mem[tail_ff] <= req_thread_id;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         head_data_ff <= queue_mem[head_ff];
      end
   end

   // Result staged alongside the registered read of the head entry.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         stage_outcome_ff <= outcome_in;
         stage_count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_outcome_ff   <= stage_outcome_ff;
         rsp_count_now_ff <= stage_count_ff;
         rsp_woken_id_ff  <= (stage_outcome_ff == csfw_pkg::OUT_WOKEN) ? head_data_ff : '0;
      end
   end

   assign cfg_rdata     = initial_count_ff;
   assign rsp_outcome   = rsp_outcome_ff;
   assign rsp_woken_id  = rsp_woken_id_ff;
   assign rsp_count_now = rsp_count_now_ff;

endmodule

### rtl/core/csfw_checker.sv
// ----------------------------------------------------------------------------
// csfw_checker
// Port-level checks on the semaphore core, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csfw_checker #(
   parameter int unsigned ID_BITS = csfw_pkg::DEF_ID_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [2:0]                    rsp_outcome,
   input logic [ID_BITS-1:0]            rsp_woken_id,
   input logic [csfw_pkg::COUNT_W-1:0]  rsp_count_now
);

   // A result beat that the receiver stalls stays offered.
   `CSFW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result beat withdrawn while stalled")

   // Reset leaves no result beat on offer.
   `CSFW_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

   // Only a woken waiter carries an id.
   `CSFW_ASSERT(a_woken_zero, clock, reset, rsp_valid && (rsp_outcome != csfw_pkg::OUT_WOKEN) |-> rsp_woken_id == '0, "woken id not zero")

   // A signal that finds no waiter always leaves a count of at least one.
   `CSFW_ASSERT(a_no_waiter_count, clock, reset, rsp_valid && (rsp_outcome == csfw_pkg::OUT_NO_WAITER) |-> rsp_count_now != '0, "count zero after signal")

   // An accepted request reaches the output as soon as the output register can take its beat.
   `CSFW_ASSERT(a_latency, clock, reset, (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid, "result beat late")

endmodule

bind counting_semaphore_fifo_waiters_core csfw_checker #(.ID_BITS(ID_BITS)) u_csfw_checker (.*);
